// File: hw/rtl/m4v4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4v4_pkg: shared types and constants for the 4x4 matrix-vector transform
// Q16.16 word types, accumulator widths, register map and matrix reset value.
// ----------------------------------------------------------------------------
package m4v4_pkg;

	// Fixed-point format
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int DIM       = 4;

	// Register map: eight 64-bit registers, two matrix entries each
	localparam int NUM_REGS  = 8;
	localparam int DATA_W    = 64;
	localparam int REG_OFS_W = 3;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int ADDR_W    = REG_IDX_W + REG_OFS_W;

	typedef logic signed [WORD_W-1:0]       word_t;
	typedef logic signed [2*WORD_W-1:0]     prod_t;   // one product
	typedef logic signed [2*WORD_W:0]       psum_t;   // sum of two products
	typedef logic signed [2*WORD_W+1:0]     sum_t;    // sum of four products
	typedef logic        [2*WORD_W+1:0]     mag_t;    // magnitude of a row sum
	typedef logic        [DATA_W-1:0]       reg_t;
	typedef logic        [REG_IDX_W-1:0]    reg_idx_t;

	// Saturation limits
	localparam word_t SAT_POS = word_t'({1'b0, {(WORD_W-1){1'b1}}});
	localparam word_t SAT_NEG = word_t'({1'b1, {(WORD_W-1){1'b0}}});

	// Identity matrix at Q16.16
	localparam reg_t MAT_RESET [NUM_REGS] = '{
		64'd65536, 64'd0, 64'd281474976710656, 64'd0,
		64'd0, 64'd65536, 64'd0, 64'd281474976710656
	};

endpackage

// File: hw/rtl/m4v4_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4v4_if: streaming channels of the matrix-vector transform
// Vertex request channel and transformed result channel, valid/ready.
// ----------------------------------------------------------------------------

// Input vertex: four Q16.16 components
interface m4v4_vertex_if import m4v4_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t in_x;
	word_t in_y;
	word_t in_z;
	word_t in_w;

	modport source (output valid, in_x, in_y, in_z, in_w, input ready);
	modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
	modport monitor (input valid, ready, in_x, in_y, in_z, in_w);
endinterface

// Transformed vertex plus saturation flag
interface m4v4_result_if import m4v4_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t out_x;
	word_t out_y;
	word_t out_z;
	word_t out_w;
	logic  clipped;

	modport source (output valid, out_x, out_y, out_z, out_w, clipped, input ready);
	modport sink   (input valid, out_x, out_y, out_z, out_w, clipped, output ready);
	modport monitor (input valid, ready, out_x, out_y, out_z, out_w, clipped);
endinterface

// File: hw/rtl/mat4_vec4_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_vec4_transform_core: 4x4 matrix times 4-vector, Q16.16
// Five-stage pipeline: products, pair sums, row sums, magnitude, shift and
// saturate. Matrix is held in eight 64-bit APB registers.
// ----------------------------------------------------------------------------
//
//  channel   | role        | payload
//  ----------+-------------+------------------------------------------
//  vertex    | request in  | in_x, in_y, in_z, in_w (Q16.16)
//  result    | request out | out_x, out_y, out_z, out_w, clipped
//  apb       | config      | 64-bit matrix registers at 8*i
//
//  One vertex per cycle while result is not stalled; five register stages
//  (multiply, two adder levels, abs, shift/sat) lie between an accepted
//  request and its result.
//  Each stage holds its own valid bit; a stage loads whenever it is empty or
//  the next stage moves, so a stall on result backs up without losing data.
//  Reset clears the valid bits and loads the identity matrix.
//
module mat4_vec4_transform_core import m4v4_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// Streams
	m4v4_vertex_if.sink         vertex,
	m4v4_result_if.source       result
);

	reg_t     mat_q [NUM_REGS];
	reg_idx_t reg_idx;
	word_t    ent [DIM][DIM];
	word_t    vec [DIM];

	// Stage registers
	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic  rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	prod_t prod_s1 [DIM][DIM];
	psum_t psum_s2 [DIM][2];
	sum_t  sum_s3  [DIM];
	mag_t  mag_s4  [DIM];
	logic  neg_s4  [DIM];
	word_t res_s5  [DIM];
	logic  clip_s5;

	// Combinational next values
	prod_t prod_d [DIM][DIM];
	psum_t psum_d [DIM][2];
	sum_t  sum_d  [DIM];
	mag_t  mag_d  [DIM];
	word_t res_d  [DIM];
	logic  [DIM-1:0] clip_d;

	// Register file
	assign reg_idx = paddr[ADDR_W-1:REG_OFS_W];
	assign pready  = 1'b1;
	assign prdata  = mat_q[reg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				mat_q[i] <= MAT_RESET[i];
			end
		end else if (psel && penable && pwrite && pready) begin
			mat_q[reg_idx] <= pwdata;
		end
	end

	// Matrix entries, row-major, two per register
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				ent[r][c] = word_t'(mat_q[r*2 + c/2][(c%2)*WORD_W +: WORD_W]);
			end
		end
	end

	assign vec[0] = vertex.in_x;
	assign vec[1] = vertex.in_y;
	assign vec[2] = vertex.in_z;
	assign vec[3] = vertex.in_w;

	// Ready chain: a stage takes new data when empty or draining
	assign rdy_s5       = !v_s5 || result.ready;
	assign rdy_s4       = !v_s4 || rdy_s5;
	assign rdy_s3       = !v_s3 || rdy_s4;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign vertex.ready = rdy_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= vertex.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: sixteen 32x32 signed products
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				prod_d[r][c] = prod_t'(ent[r][c]) * prod_t'(vec[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && vertex.valid) prod_s1 <= prod_d;
	end

	// Stage 2: pair sums per row
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			psum_d[r][0] = psum_t'(prod_s1[r][0]) + psum_t'(prod_s1[r][1]);
			psum_d[r][1] = psum_t'(prod_s1[r][2]) + psum_t'(prod_s1[r][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) psum_s2 <= psum_d;
	end

	// Stage 3: full row sum, exact
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			sum_d[r] = sum_t'(psum_s2[r][0]) + sum_t'(psum_s2[r][1]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) sum_s3 <= sum_d;
	end

	// Stage 4: sign and magnitude, so the shift truncates toward zero
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			mag_d[r] = sum_s3[r][2*WORD_W+1] ? mag_t'(~sum_s3[r]) + mag_t'(1)
			                                 : mag_t'(sum_s3[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			mag_s4 <= mag_d;
			for (int r = 0; r < DIM; r++) begin
				neg_s4[r] <= sum_s3[r][2*WORD_W+1];
			end
		end
	end

	// Stage 5: drop fraction bits, saturate, restore sign
	always_comb begin
		mag_t q;
		for (int r = 0; r < DIM; r++) begin
			q = mag_s4[r] >> FRAC_BITS;
			if (!neg_s4[r]) begin
				clip_d[r] = q > mag_t'(SAT_POS);
				res_d[r]  = clip_d[r] ? SAT_POS : word_t'(q[WORD_W-1:0]);
			end else begin
				clip_d[r] = q > mag_t'({1'b1, {(WORD_W-1){1'b0}}});
				res_d[r]  = clip_d[r] ? SAT_NEG : word_t'(-q[WORD_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			res_s5  <= res_d;
			clip_s5 <= |clip_d;
		end
	end

	// Result port
	assign result.valid   = v_s5;
	assign result.out_x   = res_s5[0];
	assign result.out_y   = res_s5[1];
	assign result.out_z   = res_s5[2];
	assign result.out_w   = res_s5[3];
	assign result.clipped = clip_s5;

endmodule

// File: hw/rtl/m4v4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4v4_checker: port-level checks for the matrix-vector transform
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module m4v4_checker import m4v4_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vtx_ready,
	input  logic              res_valid,
	input  logic              res_ready,
	input  word_t             res_x,
	input  word_t             res_y,
	input  word_t             res_z,
	input  word_t             res_w,
	input  logic              res_clip
);

	// A stalled result keeps its request up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped under stall");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			$stable(res_x) && $stable(res_y) &&
			$stable(res_z) && $stable(res_w) && $stable(res_clip))
		else $error("result payload changed under stall");

	// Clipped flag only with a component at a saturation limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_clip |->
			(res_x == SAT_POS || res_x == SAT_NEG ||
			 res_y == SAT_POS || res_y == SAT_NEG ||
			 res_z == SAT_POS || res_z == SAT_NEG ||
			 res_w == SAT_POS || res_w == SAT_NEG))
		else $error("clipped set without a saturated component");

	// A draining output leaves the pipeline open for a new vertex
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> vtx_ready)
		else $error("vertex stalled while result is drained");

	// Nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("result valid right after reset");

endmodule

bind mat4_vec4_transform_core m4v4_checker u_m4v4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.vtx_ready (vertex.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_x     (result.out_x),
	.res_y     (result.out_y),
	.res_z     (result.out_z),
	.res_w     (result.out_w),
	.res_clip  (result.clipped)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream test of the 4x4 matrix times 4-vector transform core
// Loads a series of matrices over APB while the core is idle, streams vertex
// requests with random gaps on both channels, predicts every transformed
// vertex and compares each result request field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	import m4v4_pkg::*;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		word_t w;
	} vertex_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		word_t w;
		logic  clip;
	} xform_t;

	localparam int RAND_PHASES    = 6;
	localparam int RAND_PER_PHASE = 242;
	localparam int LONG_HOLD      = 400;
	localparam int TAIL_CYCLES    = 20;

	logic clk;
	logic arst_n;

	// APB configuration port
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	m4v4_vertex_if vtx ();
	m4v4_result_if res ();

	mat4_vec4_transform_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.vertex  (vtx.sink),
		.result  (res.source)
	);

	// Matrix as the core should hold it, and traffic bookkeeping
	reg_t    mat_shadow [NUM_REGS];
	vertex_t vertex_q [$];
	xform_t  xform_q [$];
	int      error_cnt   = 0;
	int      vertex_cnt  = 0;
	int      result_cnt  = 0;
	int      clip_cnt    = 0;
	int      setting_cnt = 0;
	int      idle_pct    = 0;
	logic    hold_arm    = 1'b0;

	int   src_gap;
	int   sink_gap;
	int   hold_cnt;
	logic hold_used;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic word_t mat_entry(input int r, input int c);
		reg_t rr;
		rr = mat_shadow[r*2 + c/2];
		return (c % 2) ? word_t'(rr[63:32]) : word_t'(rr[31:0]);
	endfunction

	// One row: exact sum, truncate toward zero, saturate
	function automatic word_t row_dot(input int r, input word_t vec [4], inout logic clip);
		sum_t        acc;
		prod_t       p;
		mag_t        mag;
		mag_t        q;
		logic        neg;
		logic [31:0] low;
		acc = '0;
		for (int c = 0; c < DIM; c++) begin
			p   = mat_entry(r, c) * vec[c];
			acc = acc + p;
		end
		neg = acc[$bits(sum_t)-1];
		mag = neg ? mag_t'(-acc) : mag_t'(acc);
		q   = mag >> FRAC_BITS;
		low = q[31:0];
		if (!neg) begin
			if (q > mag_t'(32'h7FFF_FFFF)) begin
				clip = 1'b1;
				return SAT_POS;
			end
			return word_t'(low);
		end
		if (q > mag_t'(32'h8000_0000)) begin
			clip = 1'b1;
			return SAT_NEG;
		end
		return word_t'(-low);
	endfunction

	function automatic xform_t transform_vertex(input vertex_t v);
		xform_t o;
		word_t  vec [4];
		logic   clip;
		vec[0] = v.x;
		vec[1] = v.y;
		vec[2] = v.z;
		vec[3] = v.w;
		clip   = 1'b0;
		o.x    = row_dot(0, vec, clip);
		o.y    = row_dot(1, vec, clip);
		o.z    = row_dot(2, vec, clip);
		o.w    = row_dot(3, vec, clip);
		o.clip = clip;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Random values: 0 any bits, 1 within +-4.0, 2 corner values or any
	// ------------------------------------------------------------------
	function automatic word_t rand_word(input int mode);
		int m;
		m = (mode > 2) ? $urandom_range(0, 2) : mode;
		case (m)
			0: return word_t'($urandom);
			1: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			default: begin
				case ($urandom_range(0, 7))
					0: return SAT_POS;
					1: return SAT_NEG;
					2: return '0;
					3: return word_t'(1);
					4: return word_t'(-1);
					5: return word_t'(32'h0001_0000);
					6: return word_t'(32'hFFFF_0000);
					default: return word_t'($urandom);
				endcase
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Vertex driver: offers queued requests, predicts each accepted one
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx.valid <= 1'b0;
			vtx.in_x  <= '0;
			vtx.in_y  <= '0;
			vtx.in_z  <= '0;
			vtx.in_w  <= '0;
			src_gap   <= 0;
		end else begin
			if (vtx.valid && vtx.ready) begin
				xform_q.push_back(transform_vertex({vtx.in_x, vtx.in_y, vtx.in_z, vtx.in_w}));
				vertex_cnt++;
			end
			if (!vtx.valid || vtx.ready) begin
				if (src_gap > 0) begin
					src_gap   <= src_gap - 1;
					vtx.valid <= 1'b0;
				end else if (vertex_q.size() == 0) begin
					vtx.valid <= 1'b0;
				end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
					// start an idle burst, its length drawn at random
					src_gap   <= $urandom_range(0, 15);
					vtx.valid <= 1'b0;
				end else begin
					vertex_t v;
					v = vertex_q.pop_front();
					vtx.valid <= 1'b1;
					vtx.in_x  <= v.x;
					vtx.in_y  <= v.y;
					vtx.in_z  <= v.z;
					vtx.in_w  <= v.w;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result ready: random stall bursts plus one long hold on request
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			sink_gap  <= 0;
			hold_cnt  <= 0;
			hold_used <= 1'b0;
		end else if (hold_arm && !hold_used) begin
			hold_used <= 1'b1;
			hold_cnt  <= LONG_HOLD - 1;
			res.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt  <= hold_cnt - 1;
			res.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap  <= sink_gap - 1;
			res.ready <= 1'b0;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			sink_gap  <= $urandom_range(0, 15);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare against the oldest prediction
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, e, a);
			error_cnt++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (xform_q.size() == 0) begin
				$display("%0t: unexpected result, actual %h %h %h %h clip %b", $realtime,
					res.out_x, res.out_y, res.out_z, res.out_w, res.clipped);
				error_cnt++;
			end else begin
				xform_t e;
				e = xform_q.pop_front();
				check_field("out_x", e.x, res.out_x);
				check_field("out_y", e.y, res.out_y);
				check_field("out_z", e.z, res.out_z);
				check_field("out_w", e.w, res.out_w);
				check_field("clipped", 32'(e.clip), 32'(res.clipped));
				if (e.clip)
					clip_cnt++;
			end
			result_cnt++;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic apb_write(input int idx, input reg_t val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 8);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		mat_shadow[idx] = val;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// m is row-major; register i holds entries 2i (low) and 2i+1 (high)
	task automatic load_matrix(input word_t m [16]);
		for (int i = 0; i < NUM_REGS; i++)
			apb_write(i, {m[2*i+1], m[2*i]});
		setting_cnt++;
	endtask

	task automatic push_vertex(input word_t x, input word_t y, input word_t z, input word_t w);
		vertex_t v;
		v = {x, y, z, w};
		vertex_q.push_back(v);
	endtask

	// Wait until the core holds nothing: all requests sent and answered
	task automatic drain();
		@(negedge clk);
		while (vertex_q.size() != 0 || vtx.valid || xform_q.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		word_t mat [16];
		int    mat_mode [RAND_PHASES] = '{1, 0, 2, 1, 2, 0};
		int    idle_set [RAND_PHASES] = '{20, 10, 25, 0, 15, 0};

		arst_n    = 1'b0;
		for (int i = 0; i < NUM_REGS; i++)
			mat_shadow[i] = MAT_RESET[i];
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);

		// Identity from reset, with light idling
		idle_pct = 15;
		setting_cnt++;
		push_vertex('0, '0, '0, '0);
		push_vertex(SAT_POS, SAT_POS, SAT_POS, SAT_POS);
		push_vertex(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG);
		push_vertex(word_t'(1), word_t'(-1), word_t'(32'h0001_0000), word_t'(32'hFFFF_0000));
		push_vertex(SAT_POS, SAT_NEG, word_t'(1), word_t'(-1));
		push_vertex(rand_word(0), rand_word(0), rand_word(0), rand_word(0));
		drain();

		// Half on the diagonal, minus half beside it: truncation of negative sums
		for (int i = 0; i < 16; i++)
			mat[i] = (i % 5 == 0) ? word_t'(32'h0000_8000) :
				(i % 5 == 1) ? word_t'(32'hFFFF_8000) : '0;
		load_matrix(mat);
		push_vertex(word_t'(-1), word_t'(-1), word_t'(-1), word_t'(-1));
		push_vertex(word_t'(1), word_t'(1), word_t'(1), word_t'(1));
		push_vertex(word_t'(-3), word_t'(3), word_t'(32'hFFFE_FFFF), word_t'(32'h0001_0001));
		push_vertex(SAT_NEG, SAT_POS, SAT_NEG, SAT_POS);
		drain();

		// Largest positive entries: overflow both ways
		for (int i = 0; i < 16; i++)
			mat[i] = SAT_POS;
		load_matrix(mat);
		push_vertex(SAT_POS, SAT_POS, SAT_POS, SAT_POS);
		push_vertex(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG);
		push_vertex('0, '0, '0, '0);
		push_vertex(word_t'(1), '0, '0, '0);
		push_vertex(SAT_POS, SAT_NEG, SAT_POS, SAT_NEG);
		drain();

		// Most negative entries
		for (int i = 0; i < 16; i++)
			mat[i] = SAT_NEG;
		load_matrix(mat);
		push_vertex(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG);
		push_vertex(SAT_POS, SAT_POS, SAT_POS, SAT_POS);
		push_vertex(SAT_NEG, '0, '0, '0);
		push_vertex(word_t'(-1), '0, '0, '0);
		drain();

		// Register extremes: all zero, then all ones
		for (int i = 0; i < 16; i++)
			mat[i] = '0;
		load_matrix(mat);
		push_vertex(SAT_POS, SAT_NEG, rand_word(0), rand_word(0));
		drain();
		for (int i = 0; i < 16; i++)
			mat[i] = word_t'(-1);
		load_matrix(mat);
		push_vertex(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG);
		push_vertex(rand_word(0), rand_word(0), rand_word(0), rand_word(0));
		drain();

		// Random matrices and vertex streams
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			for (int i = 0; i < 16; i++)
				mat[i] = rand_word(mat_mode[ph]);
			load_matrix(mat);
			idle_pct = idle_set[ph];
			for (int n = 0; n < RAND_PER_PHASE; n++)
				push_vertex(rand_word(3), rand_word(3), rand_word(3), rand_word(3));
			// long result hold-off while requests keep coming
			if (ph == 2) begin
				@(posedge clk);
				hold_arm <= 1'b1;
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (xform_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $realtime, xform_q.size());
			error_cnt++;
		end
		$display("Streamed %0d vertices under %0d matrix settings; %0d results compared,",
			vertex_cnt, setting_cnt, result_cnt);
		$display("%0d of them saturated, %0d mismatches.", clip_cnt, error_cnt);
		if (error_cnt == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Run did not finish in time, %0d results outstanding", xform_q.size());
		$display("testbench: errors");
		$finish;
	end

endmodule
